// ----- hw/rtl/glyph_quad_vertex_generator_core_macros.svh -----
// Assertion macros used by the vertex sequencer of the glyph quad vertex generator.
`ifndef GLYPH_QUAD_VERTEX_GENERATOR_CORE_MACROS_SVH
`define GLYPH_QUAD_VERTEX_GENERATOR_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GQV_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gqv: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define GQV_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gqv: next-cycle check failed");

`endif

// ----- hw/rtl/gqv_pkg.sv -----
// Types, constants and saturation helpers for the glyph quad vertex generator.
`default_nettype none

package gqv_pkg;

   // Table depth and internal screen coordinate width.
   localparam int GLYPH_COUNT = 256;
   localparam int COORD_BITS = 16;

   localparam int GLYPH_IDX_BITS = $clog2(GLYPH_COUNT);
   localparam logic [8:0] GLYPH_LIMIT = 9'(GLYPH_COUNT);
   localparam int EXT_BITS = (COORD_BITS > 16) ? COORD_BITS : 16;
   // Headroom for pen plus bearing plus size without overflow.
   localparam int WIDE_BITS = EXT_BITS + 3;

   localparam logic [7:0] NEWLINE_CODE = 8'd10;

   // Request operations.
   localparam logic OP_GLYPH_WRITE = 1'b0;
   localparam logic OP_PLACE_CHAR = 1'b1;

   // Configuration register indexes.
   localparam logic [1:0] CSR_START_X = 2'd0;
   localparam logic [1:0] CSR_START_Y = 2'd1;
   localparam logic [1:0] CSR_LINE_SPACING = 2'd2;
   localparam logic [9:0] LINE_SPACING_RESET = 10'd16;

   // Vertex positions within one character's group.
   localparam logic [2:0] VTX_STITCH_HEAD = 3'd0;
   localparam logic [2:0] VTX_TOP_LEFT = 3'd1;
   localparam logic [2:0] VTX_BOTTOM_LEFT = 3'd2;
   localparam logic [2:0] VTX_TOP_RIGHT = 3'd3;
   localparam logic [2:0] VTX_BOTTOM_RIGHT = 3'd4;
   localparam logic [2:0] VTX_STITCH_TAIL = 3'd5;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [WIDE_BITS-1:0] wide_type;

   localparam coord_type COORD_MAX = coord_type'(2 ** (COORD_BITS - 1) - 1);
   localparam coord_type COORD_MIN = coord_type'(-(2 ** (COORD_BITS - 1)));
   localparam wide_type COORD_MAX_W = wide_type'(2 ** (COORD_BITS - 1) - 1);
   localparam wide_type COORD_MIN_W = wide_type'(-(2 ** (COORD_BITS - 1)));

   typedef struct packed {
      logic [9:0] left;
      logic [9:0] top;
      logic [8:0] width;
      logic [8:0] height;
   } geometry_type;

   typedef struct packed {
      logic [11:0] atlas_x;
      logic [11:0] atlas_y;
      logic [8:0] advance;
   } atlas_type;

   typedef struct packed {
      geometry_type geo;
      atlas_type atl;
   } glyph_entry_type;

   // Corner coordinates of one quad, already saturated and in output format.
   typedef struct packed {
      logic [15:0] x0;
      logic [15:0] x1;
      logic [15:0] y0;
      logic [15:0] y1;
      logic [12:0] s0;
      logic [12:0] s1;
      logic [12:0] t0;
      logic [12:0] t1;
   } quad_type;

   // Clamp a wide exact value to the signed coordinate range.
   function automatic coord_type saturate(wide_type v);
      coord_type r;
      if (v > COORD_MAX_W) begin
         r = COORD_MAX;
      end else if (v < COORD_MIN_W) begin
         r = COORD_MIN;
      end else begin
         r = coord_type'(v);
      end
      return r;
   endfunction

   // Sign-extend or truncate a coordinate to the 16-bit output field.
   function automatic logic [15:0] to_out16(coord_type c);
      logic signed [EXT_BITS-1:0] e;
      e = EXT_BITS'(c);
      return e[15:0];
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/gqv_channels.sv -----
// Valid/ready channel interfaces for request, response and register write.
`default_nettype none

interface gqv_req_if;
   logic valid;
   logic ready;
   logic operation;
   logic [7:0] char_code;
   logic new_string;
   logic signed [9:0] glyph_left;
   logic signed [9:0] glyph_top;
   logic [8:0] glyph_width;
   logic [8:0] glyph_height;
   logic [11:0] atlas_x;
   logic [11:0] atlas_y;
   logic [8:0] glyph_advance;

   modport source (
      output valid, operation, char_code, new_string, glyph_left, glyph_top,
         glyph_width, glyph_height, atlas_x, atlas_y, glyph_advance,
      input ready
   );
   modport sink (
      input valid, operation, char_code, new_string, glyph_left, glyph_top,
         glyph_width, glyph_height, atlas_x, atlas_y, glyph_advance,
      output ready
   );
endinterface

interface gqv_rsp_if;
   logic valid;
   logic ready;
   logic signed [15:0] vertex_x;
   logic signed [15:0] vertex_y;
   logic [12:0] tex_s;
   logic [12:0] tex_t;
   logic [2:0] vertex_index;
   logic last;

   modport source (
      output valid, vertex_x, vertex_y, tex_s, tex_t, vertex_index, last,
      input ready
   );
   modport sink (
      input valid, vertex_x, vertex_y, tex_s, tex_t, vertex_index, last,
      output ready
   );
endinterface

interface gqv_csr_if;
   logic valid;
   logic ready;
   logic [1:0] index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/gqv_vertex_emit.sv -----
// Quad register and six-beat vertex sequencer driving the response channel.
`default_nettype none
`include "glyph_quad_vertex_generator_core_macros.svh"

module gqv_vertex_emit (
   input wire logic clock,
   input wire logic reset,
   input wire gqv_pkg::quad_type load_quad,
   input wire logic load_valid,
   output logic load_ready,
   gqv_rsp_if.source rsp
);

   logic c_valid_ff, c_valid_in;
   logic [2:0] cnt_ff, cnt_in;
   gqv_pkg::quad_type quad_ff, quad_in;
   logic beat;
   logic final_beat;

   // A response beat moves one vertex; the sixth frees the quad register.
   assign beat = rsp.valid && rsp.ready;
   assign final_beat = beat && (cnt_ff == gqv_pkg::VTX_STITCH_TAIL);
   assign load_ready = !c_valid_ff || final_beat;

   // Next state of the sequencer.
   always_comb begin
      c_valid_in = c_valid_ff;
      cnt_in = cnt_ff;
      quad_in = quad_ff;
      if (load_valid && load_ready) begin
         c_valid_in = 1'b1;
         cnt_in = gqv_pkg::VTX_STITCH_HEAD;
         quad_in = load_quad;
      end else if (final_beat) begin
         c_valid_in = 1'b0;
      end else if (beat) begin
         cnt_in = cnt_ff + 3'd1;
      end
   end

   // Control state is reset; the quad payload is not.
   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
         cnt_ff <= gqv_pkg::VTX_STITCH_HEAD;
      end else begin
         c_valid_ff <= c_valid_in;
         cnt_ff <= cnt_in;
      end
      quad_ff <= quad_in;
   end

   // Pick the corner for the current vertex of the strip.
   always_comb begin
      rsp.valid = c_valid_ff;
      rsp.vertex_index = cnt_ff;
      rsp.last = (cnt_ff == gqv_pkg::VTX_STITCH_TAIL);
      case (cnt_ff)
         gqv_pkg::VTX_STITCH_HEAD: begin
            rsp.vertex_x = quad_ff.x0;
            rsp.vertex_y = quad_ff.y0;
            rsp.tex_s = '0;
            rsp.tex_t = '0;
         end
         gqv_pkg::VTX_TOP_LEFT: begin
            rsp.vertex_x = quad_ff.x0;
            rsp.vertex_y = quad_ff.y0;
            rsp.tex_s = quad_ff.s0;
            rsp.tex_t = quad_ff.t0;
         end
         gqv_pkg::VTX_BOTTOM_LEFT: begin
            rsp.vertex_x = quad_ff.x0;
            rsp.vertex_y = quad_ff.y1;
            rsp.tex_s = quad_ff.s0;
            rsp.tex_t = quad_ff.t1;
         end
         gqv_pkg::VTX_TOP_RIGHT: begin
            rsp.vertex_x = quad_ff.x1;
            rsp.vertex_y = quad_ff.y0;
            rsp.tex_s = quad_ff.s1;
            rsp.tex_t = quad_ff.t0;
         end
         gqv_pkg::VTX_BOTTOM_RIGHT: begin
            rsp.vertex_x = quad_ff.x1;
            rsp.vertex_y = quad_ff.y1;
            rsp.tex_s = quad_ff.s1;
            rsp.tex_t = quad_ff.t1;
         end
         default: begin
            rsp.vertex_x = quad_ff.x1;
            rsp.vertex_y = quad_ff.y1;
            rsp.tex_s = '0;
            rsp.tex_t = '0;
         end
      endcase
   end

   // A group is never cut short, vertices step by one, and a waiting quad holds.
   `GQV_ASSERT_NXT(group_continues_a, clock, reset, beat && !rsp.last, c_valid_ff)
   `GQV_ASSERT_NXT(index_steps_a, clock, reset, beat && !rsp.last, cnt_ff == $past(cnt_ff) + 3'd1)
   `GQV_ASSERT_NXT(quad_holds_a, clock, reset, c_valid_ff && !beat, $stable(quad_ff))

endmodule

`default_nettype wire

// ----- hw/rtl/glyph_quad_vertex_generator_core.sv -----
// Top level of the glyph quad vertex generator: glyph table, pen and quad setup.
//
//   Channel   Direction  Beat carries
//   req_chan  in         glyph table write or character to place
//   rsp_chan  out        one vertex; six per placed character
//   csr_chan  in         start_x, start_y, line_spacing register write
//
// A placed character produces six response vertices, one per response beat,
// and a glyph write produces no response. A character passes the table read
// into the lookup stage, then quad setup into the sequencer's quad register,
// before its first vertex. Reset clears the pen, registers and pipeline valids;
// the glyph table is not cleared. Either side may stall freely.
`default_nettype none

module glyph_quad_vertex_generator_core (
   input wire logic clock,
   input wire logic reset,
   gqv_req_if.sink req_chan,
   gqv_rsp_if.source rsp_chan,
   gqv_csr_if.sink csr_chan
);

   // Configuration registers.
   logic [15:0] start_x_ff;
   logic [15:0] start_y_ff;
   logic [9:0] spacing_ff;

   // Glyph table, written and read in clocked blocks.
   gqv_pkg::glyph_entry_type glyph_mem [gqv_pkg::GLYPH_COUNT];

   // Lookup stage holding one character between table read and quad setup.
   logic b_valid_ff, b_valid_in;
   gqv_pkg::glyph_entry_type b_entry_ff;
   logic b_in_range_ff;
   logic b_newline_ff;
   logic b_new_string_ff;

   gqv_pkg::coord_type pen_x_ff, pen_y_ff;

   logic emit_ready;
   logic b_move;
   logic req_beat;
   logic char_beat;
   logic code_in_range;
   logic [gqv_pkg::GLYPH_IDX_BITS-1:0] glyph_idx;
   gqv_pkg::glyph_entry_type write_entry;

   gqv_pkg::geometry_type geo;
   gqv_pkg::atlas_type atl;
   gqv_pkg::coord_type start_x_sat, start_y_sat;
   gqv_pkg::coord_type base_y;
   gqv_pkg::coord_type px, py;
   gqv_pkg::coord_type pen_x_next;
   gqv_pkg::wide_type x0_w, x1_w, y0_w, y1_w;
   gqv_pkg::quad_type quad;

   // Configuration writes are always taken.
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff <= '0;
         start_y_ff <= '0;
         spacing_ff <= gqv_pkg::LINE_SPACING_RESET;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            gqv_pkg::CSR_START_X: start_x_ff <= csr_chan.data;
            gqv_pkg::CSR_START_Y: start_y_ff <= csr_chan.data;
            gqv_pkg::CSR_LINE_SPACING: spacing_ff <= csr_chan.data[9:0];
            default: begin
            end
         endcase
      end
   end

   // Request side: room when the lookup stage is empty or moving on.
   assign b_move = b_valid_ff && emit_ready;
   assign req_chan.ready = !b_valid_ff || emit_ready;
   assign req_beat = req_chan.valid && req_chan.ready;
   assign char_beat = req_beat && (req_chan.operation == gqv_pkg::OP_PLACE_CHAR);
   assign code_in_range = {1'b0, req_chan.char_code} < gqv_pkg::GLYPH_LIMIT;
   assign glyph_idx = req_chan.char_code[gqv_pkg::GLYPH_IDX_BITS-1:0];

   always_comb begin
      write_entry.geo.left = req_chan.glyph_left;
      write_entry.geo.top = req_chan.glyph_top;
      write_entry.geo.width = req_chan.glyph_width;
      write_entry.geo.height = req_chan.glyph_height;
      write_entry.atl.atlas_x = req_chan.atlas_x;
      write_entry.atl.atlas_y = req_chan.atlas_y;
      write_entry.atl.advance = req_chan.glyph_advance;
   end

   // Table write for glyph loads, registered read for characters.
   always_ff @(posedge clock) begin
      if (req_beat && (req_chan.operation == gqv_pkg::OP_GLYPH_WRITE) && code_in_range) begin
         glyph_mem[glyph_idx] <= write_entry;
      end
      if (char_beat) begin
         b_entry_ff <= glyph_mem[glyph_idx];
         b_in_range_ff <= code_in_range;
         b_newline_ff <= (req_chan.char_code == gqv_pkg::NEWLINE_CODE);
         b_new_string_ff <= req_chan.new_string;
      end
   end

   always_comb begin
      b_valid_in = b_valid_ff;
      if (char_beat) begin
         b_valid_in = 1'b1;
      end else if (b_move) begin
         b_valid_in = 1'b0;
      end
   end

   // Codes beyond the table place an all-zero glyph.
   always_comb begin
      if (b_in_range_ff) begin
         geo = b_entry_ff.geo;
         atl = b_entry_ff.atl;
      end else begin
         geo = '0;
         atl = '0;
      end
   end

   // Pen position for this character after string start and newline.
   always_comb begin
      start_x_sat = gqv_pkg::saturate(gqv_pkg::wide_type'($signed(start_x_ff)));
      start_y_sat = gqv_pkg::saturate(gqv_pkg::wide_type'($signed(start_y_ff)));
      base_y = b_new_string_ff ? start_y_sat : pen_y_ff;
      px = b_new_string_ff ? start_x_sat : pen_x_ff;
      py = base_y;
      if (b_newline_ff) begin
         px = start_x_sat;
         py = gqv_pkg::saturate(gqv_pkg::wide_type'(base_y)
            - gqv_pkg::wide_type'(spacing_ff));
      end
   end

   // Exact quad corners, then saturation into output format.
   always_comb begin
      x0_w = gqv_pkg::wide_type'(px) + gqv_pkg::wide_type'($signed(geo.left));
      x1_w = x0_w + gqv_pkg::wide_type'(geo.width);
      y0_w = gqv_pkg::wide_type'(py) + gqv_pkg::wide_type'($signed(geo.top));
      y1_w = y0_w - gqv_pkg::wide_type'(geo.height);
      quad.x0 = gqv_pkg::to_out16(gqv_pkg::saturate(x0_w));
      quad.x1 = gqv_pkg::to_out16(gqv_pkg::saturate(x1_w));
      quad.y0 = gqv_pkg::to_out16(gqv_pkg::saturate(y0_w));
      quad.y1 = gqv_pkg::to_out16(gqv_pkg::saturate(y1_w));
      quad.s0 = 13'(atl.atlas_x);
      quad.s1 = 13'(atl.atlas_x) + 13'(geo.width);
      quad.t0 = 13'(atl.atlas_y);
      quad.t1 = 13'(atl.atlas_y) + 13'(geo.height);
      pen_x_next = gqv_pkg::saturate(gqv_pkg::wide_type'(px)
         + gqv_pkg::wide_type'(atl.advance));
   end

   // Pen and lookup stage valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         pen_x_ff <= '0;
         pen_y_ff <= '0;
      end else begin
         b_valid_ff <= b_valid_in;
         if (b_move) begin
            pen_x_ff <= pen_x_next;
            pen_y_ff <= py;
         end
      end
   end

   gqv_vertex_emit u_emit (
      .clock(clock),
      .reset(reset),
      .load_quad(quad),
      .load_valid(b_valid_ff),
      .load_ready(emit_ready),
      .rsp(rsp_chan)
   );

endmodule

`default_nettype wire
